### rtl/core/affine_point_transform_2d_unit_defines.svh
// Assertion helpers used by the checker of the transform unit.
`ifndef AFFINE_POINT_TRANSFORM_2D_UNIT_DEFINES_SVH
`define AFFINE_POINT_TRANSFORM_2D_UNIT_DEFINES_SVH

// Overlapping implication, disabled while rst is high.
`define AFF2D_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aff2d check failed");

// Next-cycle implication, disabled while rst is high.
`define AFF2D_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aff2d check failed");

`endif

### rtl/core/aff2d_pkg.sv
package aff2d_pkg;

   localparam int OUT_WIDTH        = 42;
   localparam int PARAM_WIDTH      = 16;
   localparam int ANGLE_WIDTH      = 9;
   localparam int MODE_WIDTH       = 3;
   localparam int CSR_DATA_WIDTH   = 32;
   localparam int CSR_ADDR_WIDTH   = 5;
   localparam int ROM_DEPTH        = 91;
   localparam int ROM_INDEX_WIDTH  = 7;
   localparam int QUARTER_TURN_DEG = 90;
   localparam int HALF_TURN_DEG    = 180;
   localparam int FULL_TURN_DEG    = 360;
   localparam int Q30_FRAC_BITS    = 30;
   localparam longint unsigned PI_Q30 = 64'd3373259426;

   localparam int TAYLOR_TERMS = 10;
   localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
      '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306, 64'd380};

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_TRANSLATE = 3'd0,
      MODE_ROTATE    = 3'd1,
      MODE_SCALE     = 3'd2,
      MODE_SHEAR     = 3'd3,
      MODE_REFLECT   = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      REG_MODE         = 3'd0,
      REG_PARAM_X      = 3'd1,
      REG_PARAM_Y      = 3'd2,
      REG_ANGLE_DEG    = 3'd3,
      REG_REFLECT_AXIS = 3'd4
   } reg_idx_type;

   typedef struct packed {
      logic [MODE_WIDTH-1:0]         mode;
      logic signed [PARAM_WIDTH-1:0] param_x;
      logic signed [PARAM_WIDTH-1:0] param_y;
      logic [ANGLE_WIDTH-1:0]        angle_deg;
      logic                          reflect_axis;
   } cfg_type;

   // Cosine of a whole-degree angle in Q30, clamped at zero.
   function automatic longint unsigned cos_q30(input int unsigned deg);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      x    = (64'(deg) * PI_Q30 + 64'(HALF_TURN_DEG / 2)) / HALF_TURN_DEG;
      x2   = (x * x + (64'd1 << (Q30_FRAC_BITS - 1))) >> Q30_FRAC_BITS;
      term = 64'd1 << Q30_FRAC_BITS;
      sum  = 64'sd1 <<< Q30_FRAC_BITS;
      for (int k = 0; k < TAYLOR_TERMS; k++) begin
         term = ((term * x2) >> Q30_FRAC_BITS) / TAYLOR_DIV[k];
         if ((k % 2) == 0) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      return longint'(sum);
   endfunction

endpackage

### rtl/core/aff2d_req_if.sv
interface aff2d_req_if #(
   parameter int COORD_WIDTH = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] x_in;
   logic signed [COORD_WIDTH-1:0] y_in;

   modport source (output valid, output x_in, output y_in, input ready);
   modport sink   (input valid, input x_in, input y_in, output ready);
endinterface

### rtl/core/aff2d_rsp_if.sv
interface aff2d_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [aff2d_pkg::OUT_WIDTH-1:0]  x_out;
   logic signed [aff2d_pkg::OUT_WIDTH-1:0]  y_out;

   modport source (output valid, output x_out, output y_out, input ready);
   modport sink   (input valid, input x_out, input y_out, output ready);
endinterface

### rtl/core/aff2d_csr.sv
module aff2d_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [aff2d_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [aff2d_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [aff2d_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                  csr_pready,
   output aff2d_pkg::cfg_type                    cfg
);

   aff2d_pkg::cfg_type     cfg_ff;
   aff2d_pkg::cfg_type     cfg_in;
   aff2d_pkg::reg_idx_type reg_idx;
   logic                   wr_en;

   assign reg_idx    = aff2d_pkg::reg_idx_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            aff2d_pkg::REG_MODE:         cfg_in.mode = csr_pwdata[aff2d_pkg::MODE_WIDTH-1:0];
            aff2d_pkg::REG_PARAM_X:      cfg_in.param_x = csr_pwdata[aff2d_pkg::PARAM_WIDTH-1:0];
            aff2d_pkg::REG_PARAM_Y:      cfg_in.param_y = csr_pwdata[aff2d_pkg::PARAM_WIDTH-1:0];
            aff2d_pkg::REG_ANGLE_DEG:    cfg_in.angle_deg = csr_pwdata[aff2d_pkg::ANGLE_WIDTH-1:0];
            aff2d_pkg::REG_REFLECT_AXIS: cfg_in.reflect_axis = csr_pwdata[0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         aff2d_pkg::REG_MODE:
            csr_prdata = aff2d_pkg::CSR_DATA_WIDTH'(cfg_ff.mode);
         aff2d_pkg::REG_PARAM_X:
            csr_prdata = aff2d_pkg::CSR_DATA_WIDTH'($unsigned(cfg_ff.param_x));
         aff2d_pkg::REG_PARAM_Y:
            csr_prdata = aff2d_pkg::CSR_DATA_WIDTH'($unsigned(cfg_ff.param_y));
         aff2d_pkg::REG_ANGLE_DEG:
            csr_prdata = aff2d_pkg::CSR_DATA_WIDTH'(cfg_ff.angle_deg);
         aff2d_pkg::REG_REFLECT_AXIS:
            csr_prdata = aff2d_pkg::CSR_DATA_WIDTH'(cfg_ff.reflect_axis);
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/core/affine_point_transform_2d_unit.sv
// Channel  Dir  Fields                Word
// req      in   x_in, y_in            one signed vertex
// rsp      out  x_out, y_out          transformed vertex, 42-bit signed fixed point
// csr      in   APB registers 0..4    mode, param_x, param_y, angle_deg, reflect_axis
//
// Four register stages: operand select with cosine ROM lookup, multiply, sum, round/scale.
// rsp valid is the stage 4 valid bit; the word leaves when rsp is ready. One word enters
// per cycle while stage 1 can advance. Each stage advances when empty or the next one
// advances. A stall on rsp holds every full stage; bubbles close up while the output waits.
// Synchronous reset clears the stage valid bits and the configuration registers.
module affine_point_transform_2d_unit #(
   parameter int COORD_WIDTH    = 16,
   parameter int OUT_FRAC_BITS  = 8,
   parameter int TRIG_FRAC_BITS = 14
) (
   input  logic                                  clock,
   input  logic                                  reset,
   aff2d_req_if.sink                             req_port,
   aff2d_rsp_if.source                           rsp_port,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [aff2d_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [aff2d_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [aff2d_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                  csr_pready
);

   localparam int TW   = TRIG_FRAC_BITS + 2;
   localparam int AW   = (COORD_WIDTH > aff2d_pkg::PARAM_WIDTH) ?
                         COORD_WIDTH : aff2d_pkg::PARAM_WIDTH;
   localparam int BW   = (TW > aff2d_pkg::PARAM_WIDTH) ? TW : aff2d_pkg::PARAM_WIDTH;
   localparam int PW   = AW + BW;
   localparam int SW   = PW + 1;
   localparam int EW   = (SW + 16 > aff2d_pkg::OUT_WIDTH) ? SW + 16 : aff2d_pkg::OUT_WIDTH;
   localparam int DIFF = OUT_FRAC_BITS - TRIG_FRAC_BITS;
   localparam int UP   = (DIFF >= 0) ? DIFF : 0;
   localparam int DN   = (DIFF < 0) ? -DIFF : 0;
   localparam int RS   = aff2d_pkg::Q30_FRAC_BITS - TRIG_FRAC_BITS;

   localparam logic signed [EW-1:0] HALF   = (EW'(1) << DN) >>> 1;
   localparam logic signed [BW-1:0] B_ONE  = BW'(1);
   localparam logic signed [BW-1:0] B_NEG  = -B_ONE;
   localparam logic signed [BW-1:0] B_ZERO = '0;
   localparam logic signed [AW-1:0] A_ZERO = '0;

   typedef logic [TRIG_FRAC_BITS:0] rom_entry_type;
   typedef rom_entry_type rom_array_type [aff2d_pkg::ROM_DEPTH];

   function automatic rom_array_type build_rom();
      rom_array_type   rom;
      longint unsigned v;
      for (int d = 0; d < aff2d_pkg::ROM_DEPTH; d++) begin
         v = aff2d_pkg::cos_q30(d);
         v = (v + (64'd1 << (RS - 1))) >> RS;
         rom[d] = rom_entry_type'(v);
      end
      return rom;
   endfunction

   localparam rom_array_type COS_ROM = build_rom();

   aff2d_pkg::cfg_type cfg;

   aff2d_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // stage control
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic adv1, adv2, adv3, adv4;

   assign adv4 = !v4_ff || rsp_port.ready;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;

   assign req_port.ready = adv1;
   assign rsp_port.valid = v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_port.valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
      end
   end

   // angle reduction and ROM lookup
   logic [aff2d_pkg::ANGLE_WIDTH-1:0]     ang_mod;
   logic [aff2d_pkg::ANGLE_WIDTH-1:0]     ang_base;
   logic [1:0]                            quad;
   logic [aff2d_pkg::ROM_INDEX_WIDTH-1:0] rem;
   logic [aff2d_pkg::ROM_INDEX_WIDTH-1:0] rem_c;
   logic signed [TW-1:0]                  rom_r;
   logic signed [TW-1:0]                  rom_q;
   logic signed [TW-1:0]                  cos_v;
   logic signed [TW-1:0]                  sin_v;

   always_comb begin
      ang_mod = (cfg.angle_deg >= aff2d_pkg::ANGLE_WIDTH'(aff2d_pkg::FULL_TURN_DEG)) ?
                cfg.angle_deg - aff2d_pkg::ANGLE_WIDTH'(aff2d_pkg::FULL_TURN_DEG) :
                cfg.angle_deg;
      if (ang_mod < aff2d_pkg::ANGLE_WIDTH'(aff2d_pkg::QUARTER_TURN_DEG)) begin
         quad     = 2'd0;
         ang_base = '0;
      end else if (ang_mod < aff2d_pkg::ANGLE_WIDTH'(aff2d_pkg::HALF_TURN_DEG)) begin
         quad     = 2'd1;
         ang_base = aff2d_pkg::ANGLE_WIDTH'(aff2d_pkg::QUARTER_TURN_DEG);
      end else if (ang_mod < aff2d_pkg::ANGLE_WIDTH'(3 * aff2d_pkg::QUARTER_TURN_DEG)) begin
         quad     = 2'd2;
         ang_base = aff2d_pkg::ANGLE_WIDTH'(aff2d_pkg::HALF_TURN_DEG);
      end else begin
         quad     = 2'd3;
         ang_base = aff2d_pkg::ANGLE_WIDTH'(3 * aff2d_pkg::QUARTER_TURN_DEG);
      end
      rem   = aff2d_pkg::ROM_INDEX_WIDTH'(ang_mod - ang_base);
      rem_c = aff2d_pkg::ROM_INDEX_WIDTH'(aff2d_pkg::QUARTER_TURN_DEG) - rem;
      rom_r = $signed({1'b0, COS_ROM[rem]});
      rom_q = $signed({1'b0, COS_ROM[rem_c]});
      case (quad)
         2'd0: begin
            cos_v = rom_r;
            sin_v = rom_q;
         end
         2'd1: begin
            cos_v = -rom_q;
            sin_v = rom_r;
         end
         2'd2: begin
            cos_v = -rom_r;
            sin_v = -rom_q;
         end
         default: begin
            cos_v = rom_q;
            sin_v = -rom_r;
         end
      endcase
   end

   // stage 1: operand select
   logic signed [AW-1:0] xa, ya, pxa, pya;
   logic signed [BW-1:0] pxb, pyb, cb, sb;
   logic signed [AW-1:0] ax0_in, ax1_in, ay0_in, ay1_in;
   logic signed [BW-1:0] bx0_in, bx1_in, by0_in, by1_in;
   logic                 rot_in;
   logic signed [AW-1:0] ax0_ff, ax1_ff, ay0_ff, ay1_ff;
   logic signed [BW-1:0] bx0_ff, bx1_ff, by0_ff, by1_ff;
   logic                 rot1_ff;

   always_comb begin
      xa  = AW'(req_port.x_in);
      ya  = AW'(req_port.y_in);
      pxa = AW'(cfg.param_x);
      pya = AW'(cfg.param_y);
      pxb = BW'(cfg.param_x);
      pyb = BW'(cfg.param_y);
      cb  = BW'(cos_v);
      sb  = BW'(sin_v);
      ax0_in = xa;
      bx0_in = B_ONE;
      ax1_in = A_ZERO;
      bx1_in = B_ZERO;
      ay0_in = ya;
      by0_in = B_ONE;
      ay1_in = A_ZERO;
      by1_in = B_ZERO;
      rot_in = 1'b0;
      case (aff2d_pkg::mode_type'(cfg.mode))
         aff2d_pkg::MODE_TRANSLATE: begin
            ax1_in = pxa;
            bx1_in = B_ONE;
            ay1_in = pya;
            by1_in = B_ONE;
         end
         aff2d_pkg::MODE_ROTATE: begin
            bx0_in = cb;
            ax1_in = ya;
            bx1_in = -sb;
            by0_in = cb;
            ay1_in = xa;
            by1_in = sb;
            rot_in = 1'b1;
         end
         aff2d_pkg::MODE_SCALE: begin
            bx0_in = pxb;
            by0_in = pyb;
         end
         aff2d_pkg::MODE_SHEAR: begin
            ax1_in = ya;
            bx1_in = pxb;
            ay1_in = xa;
            by1_in = pyb;
         end
         aff2d_pkg::MODE_REFLECT: begin
            if (cfg.reflect_axis) begin
               bx0_in = B_NEG;
            end else begin
               by0_in = B_NEG;
            end
         end
         default: begin
            rot_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         ax0_ff  <= ax0_in;
         ax1_ff  <= ax1_in;
         ay0_ff  <= ay0_in;
         ay1_ff  <= ay1_in;
         bx0_ff  <= bx0_in;
         bx1_ff  <= bx1_in;
         by0_ff  <= by0_in;
         by1_ff  <= by1_in;
         rot1_ff <= rot_in;
      end
   end

   // stage 2: multiply
   logic signed [PW-1:0] px0_ff, px1_ff, py0_ff, py1_ff;
   logic                 rot2_ff;

   always_ff @(posedge clock) begin
      if (adv2) begin
         px0_ff  <= PW'(ax0_ff) * PW'(bx0_ff);
         px1_ff  <= PW'(ax1_ff) * PW'(bx1_ff);
         py0_ff  <= PW'(ay0_ff) * PW'(by0_ff);
         py1_ff  <= PW'(ay1_ff) * PW'(by1_ff);
         rot2_ff <= rot1_ff;
      end
   end

   // stage 3: sum
   logic signed [SW-1:0] sx_ff, sy_ff;
   logic                 rot3_ff;

   always_ff @(posedge clock) begin
      if (adv3) begin
         sx_ff   <= SW'(px0_ff) + SW'(px1_ff);
         sy_ff   <= SW'(py0_ff) + SW'(py1_ff);
         rot3_ff <= rot2_ff;
      end
   end

   // stage 4: round or scale to the output format
   logic signed [EW-1:0] ex, ey, rx_in, ry_in;
   logic signed [aff2d_pkg::OUT_WIDTH-1:0] x_out_ff, y_out_ff;

   always_comb begin
      ex = EW'(sx_ff);
      ey = EW'(sy_ff);
      if (rot3_ff) begin
         rx_in = ((ex + HALF) >>> DN) <<< UP;
         ry_in = ((ey + HALF) >>> DN) <<< UP;
      end else begin
         rx_in = ex <<< OUT_FRAC_BITS;
         ry_in = ey <<< OUT_FRAC_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         x_out_ff <= rx_in[aff2d_pkg::OUT_WIDTH-1:0];
         y_out_ff <= ry_in[aff2d_pkg::OUT_WIDTH-1:0];
      end
   end

   assign rsp_port.x_out = x_out_ff;
   assign rsp_port.y_out = y_out_ff;

endmodule

### rtl/core/aff2d_check.sv
`include "affine_point_transform_2d_unit_defines.svh"

module aff2d_check (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [aff2d_pkg::OUT_WIDTH-1:0]      rsp_x_out,
   input logic [aff2d_pkg::OUT_WIDTH-1:0]      rsp_y_out
);

   // hold a stalled result word
   `AFF2D_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_x_out) && $stable(rsp_y_out))

   // drop everything in flight on reset
   `AFF2D_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, !rsp_valid)

   // advance through four stages when the sink keeps taking words
   `AFF2D_ASSERT_NEXT(a_latency, clock, reset, (req_valid && req_ready) ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready, rsp_valid)

   // accept whenever the output side is free
   `AFF2D_ASSERT_IMPLY(a_no_bubble_stall, clock, reset, rsp_ready, req_ready)

endmodule

bind affine_point_transform_2d_unit aff2d_check u_aff2d_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_port.valid),
   .req_ready (req_port.ready),
   .rsp_valid (rsp_port.valid),
   .rsp_ready (rsp_port.ready),
   .rsp_x_out (rsp_port.x_out),
   .rsp_y_out (rsp_port.y_out)
);
